// ----- rtl/epc_pkg.sv -----
// ----------------------------------------------------------------------------
// Entropy pool conditioner package
// Shared constants, the queue entry type and the CRC-32 byte step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package epc_pkg;

	// Width of the fill length register and its value after reset.
	localparam int          FILL_W     = 7;
	localparam logic [6:0]  FILL_RESET = 7'd8;

	// Value of every pool byte after reset.
	localparam logic [7:0]  POOL_INIT  = 8'hAA;

	// Reflected CRC-32 polynomial and start value.
	localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;

	// Depth of the queue between the front and the back.
	localparam int          QDEPTH     = 4;
	localparam int          QPTR_W     = 2;
	localparam int          QCNT_W     = 3;

	// One whitened bit offered by the front to the back.
	typedef struct packed {
		logic valid;
		logic bit_val;
	} kbit_t;

	// One byte of a reflected CRC-32, bit by bit.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'b0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/epc_front.sv -----
// ----------------------------------------------------------------------------
// Entropy pool conditioner front
// Accepts raw bit pairs, applies the von Neumann rule and queues kept bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epc_front
	import epc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  enable,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire logic  first_raw_bit,
	input  wire logic  second_raw_bit,
	output kbit_t      kbit,
	input  wire logic  pop
);

	logic              q_bits_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;

	// Equal bits are dropped; for an unequal pair the second bit is the output.
	assign in_ready     = enable && (count_q != QCNT_W'(QDEPTH));
	assign push         = in_valid && in_ready && (first_raw_bit != second_raw_bit);
	assign kbit.valid   = (count_q != '0);
	assign kbit.bit_val = q_bits_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_bits_q[wr_ptr_q] <= second_raw_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue popped while empty");

	a_no_push_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		!enable |-> !push)
		else $error("bit queued while pool is being initialized");

endmodule

`default_nettype wire

// ----- rtl/epc_back.sv -----
// ----------------------------------------------------------------------------
// Entropy pool conditioner back
// Holds the pool memory, folds kept bits into it, mixes it and outputs words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epc_back
	import epc_pkg::*;
#(
	parameter int POOL_BYTES = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [FILL_W-1:0]  cfg_fill,
	input  wire kbit_t              kbit,
	output logic                    pop,
	output logic                    init_done,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [63:0]             out_word
);

	localparam int IDXW    = $clog2(POOL_BYTES);
	localparam int CMPW    = (IDXW + 1 > FILL_W) ? IDXW + 1 : FILL_W;
	localparam int LAST_WR = (POOL_BYTES / 4) * 4 - 1;

	localparam logic [2:0] ST_CLEAR    = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_RMW_RD   = 3'd2;
	localparam logic [2:0] ST_RMW_WR   = 3'd3;
	localparam logic [2:0] ST_MIX_RD   = 3'd4;
	localparam logic [2:0] ST_MIX_WAIT = 3'd5;
	localparam logic [2:0] ST_MIX_WR   = 3'd6;
	localparam logic [2:0] ST_EMIT     = 3'd7;

	logic [7:0]        pool_mem [POOL_BYTES];
	logic [7:0]        rd_s1;
	logic              mem_we;
	logic [IDXW-1:0]   mem_wa;
	logic [IDXW-1:0]   mem_ra;
	logic [7:0]        mem_wd;

	logic [2:0]        state_q;
	logic [IDXW-1:0]   clr_q;
	logic [IDXW-1:0]   byte_idx_q;
	logic [2:0]        bit_idx_q;
	logic [7:0]        acc_q;
	logic [FILL_W-1:0] fill_bytes_q;
	logic [IDXW-1:0]   mix_addr_q;
	logic [IDXW-1:0]   wr_addr_q;
	logic              rd_vld_s1;
	logic [1:0]        rd_k_s1;
	logic [31:0]       crc_q;
	logic [31:0]       word_q;
	logic [63:0]       stage_q;
	logic [63:0]       out_data_q;
	logic              out_valid_q;

	logic [IDXW:0]     idx_next;
	logic              mix_due;
	logic [7:0]        acc_next;
	logic [7:0]        mix_byte;
	logic [31:0]       crc_inv;
	logic              emit_load;

	assign idx_next  = {1'b0, byte_idx_q} + 1'b1;
	assign mix_due   = (CMPW'(idx_next) >= CMPW'(fill_bytes_q))
	                || (idx_next >= (IDXW + 1)'(POOL_BYTES));
	assign acc_next  = acc_q | ({7'b0, kbit.bit_val} << bit_idx_q);
	assign crc_inv   = ~crc_q;
	assign mix_byte  = word_q[{wr_addr_q[1:0], 3'b000} +: 8]
	                 ^ crc_inv[{wr_addr_q[1:0], 3'b000} +: 8];
	assign pop       = (state_q == ST_IDLE) && kbit.valid;
	assign init_done = (state_q != ST_CLEAR);
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_word  = out_data_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = byte_idx_q;
		mem_wd = rd_s1 ^ acc_q;
		mem_ra = byte_idx_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = POOL_INIT;
			end
			ST_RMW_WR: begin
				mem_we = 1'b1;
			end
			ST_MIX_RD: begin
				mem_ra = mix_addr_q;
			end
			ST_MIX_WR: begin
				mem_we = 1'b1;
				mem_wa = wr_addr_q;
				mem_wd = mix_byte;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pool_mem[mem_wa] <= mem_wd;
		end
		rd_s1 <= pool_mem[mem_ra];
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		rd_k_s1 <= mix_addr_q[1:0];
		if (state_q == ST_RMW_WR && mix_due) begin
			crc_q <= CRC_INIT;
		end else if (rd_vld_s1) begin
			crc_q <= crc_byte(crc_q, rd_s1);
			word_q[{rd_k_s1, 3'b000} +: 8] <= rd_s1;
		end
		if (state_q == ST_MIX_WR && ({1'b0, wr_addr_q} < (IDXW + 1)'(8))) begin
			stage_q[{wr_addr_q[2:0], 3'b000} +: 8] <= mix_byte;
		end
		if (emit_load) begin
			out_data_q <= stage_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			byte_idx_q   <= '0;
			bit_idx_q    <= '0;
			acc_q        <= '0;
			fill_bytes_q <= FILL_RESET;
			mix_addr_q   <= '0;
			wr_addr_q    <= '0;
			rd_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				fill_bytes_q <= cfg_fill;
			end
			rd_vld_s1 <= (state_q == ST_MIX_RD);
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDXW'(POOL_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						acc_q     <= acc_next;
						bit_idx_q <= bit_idx_q + 1'b1;
						if (bit_idx_q == 3'd7) begin
							state_q <= ST_RMW_RD;
						end
					end
				end
				ST_RMW_RD: begin
					state_q <= ST_RMW_WR;
				end
				ST_RMW_WR: begin
					acc_q <= '0;
					if (mix_due) begin
						byte_idx_q <= '0;
						mix_addr_q <= '0;
						wr_addr_q  <= '0;
						state_q    <= ST_MIX_RD;
					end else begin
						byte_idx_q <= idx_next[IDXW-1:0];
						state_q    <= ST_IDLE;
					end
				end
				ST_MIX_RD: begin
					mix_addr_q <= mix_addr_q + 1'b1;
					if (mix_addr_q[1:0] == 2'd3) begin
						state_q <= ST_MIX_WAIT;
					end
				end
				ST_MIX_WAIT: begin
					state_q <= ST_MIX_WR;
				end
				ST_MIX_WR: begin
					wr_addr_q <= wr_addr_q + 1'b1;
					if (wr_addr_q[1:0] == 2'd3) begin
						if (wr_addr_q == IDXW'(LAST_WR)) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_MIX_RD;
						end
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !pop)
		else $error("bit consumed before pool initialization finished");

	a_word_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("output word raised outside the emit step");

endmodule

`default_nettype wire

// ----- rtl/entropy_pool_conditioner_top.sv -----
// ----------------------------------------------------------------------------
// Entropy pool conditioner
// Von Neumann corrector feeding a byte pool that is mixed with a CRC-32.
// ----------------------------------------------------------------------------
// Each input transaction carries one pair of raw jitter bits. The pair 1,0
// gives the whitened bit 0 and the pair 0,1 gives the whitened bit 1; the
// pairs 0,0 and 1,1 are dropped. Whitened bits are XORed into the pool LSB
// first, byte after byte from byte 0, and once fill_bytes bytes are complete
// (a zero length acts as one, lengths above POOL_BYTES act as POOL_BYTES)
// the whole pool is mixed: a reflected CRC-32 starting at all ones runs over
// the bytes, and after every fourth byte the complemented running CRC is
// XORed into that little-endian word. Bytes 0 to 7 of the mixed pool then
// leave as one output transaction on random_word, byte 0 in the low bits,
// and filling starts over at byte 0. After reset the pool is set to 0xAA by
// a clearing pass during which in_ready stays low; configuration writes are
// accepted at any time. The front takes one pair per cycle while its
// four-entry queue has room. The back takes one whitened bit per cycle
// while it is idle, runs a read step and a write step of read-modify-write
// on the pool memory per completed byte, and a mix is paced by the single
// write and single read port of the pool memory. A finished word waits in
// the output register while the front accepts pairs until its queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module entropy_pool_conditioner_top
	import epc_pkg::*;
#(
	parameter int POOL_BYTES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [FILL_W-1:0] fill_bytes,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              first_raw_bit,
	input  wire logic              second_raw_bit,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [63:0]            random_word
);

	kbit_t kbit;
	logic  pop;
	logic  init_done;

	// The fill length register accepts a write in every cycle.
	assign cfg_ready = 1'b1;

	epc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.enable         (init_done),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.first_raw_bit  (first_raw_bit),
		.second_raw_bit (second_raw_bit),
		.kbit           (kbit),
		.pop            (pop)
	);

	epc_back #(
		.POOL_BYTES (POOL_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_fill  (fill_bytes),
		.kbit      (kbit),
		.pop       (pop),
		.init_done (init_done),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (random_word)
	);

endmodule

`default_nettype wire

// ----- sim/pool_word_checker.sv -----
// ----------------------------------------------------------------------------
// Pool word checker
// Watches the channels of the entropy pool conditioner, predicts every
// random_word from the accepted bit pairs and compares it with the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pool_word_checker
	import epc_pkg::*;
#(
	parameter int POOL_BYTES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [FILL_W-1:0] fill_bytes,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              first_raw_bit,
	input  logic              second_raw_bit,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [63:0]       random_word,
	output int                word_errors,
	output int                words_pending
);

	// Shadow copy of the pool and of the fill position.
	logic [7:0]        pool_img [POOL_BYTES];
	int                byte_pos;
	logic [2:0]        bit_pos;
	logic [FILL_W-1:0] fill_len;

	logic [63:0]       expected_words [$];
	logic [63:0]       want;
	logic [63:0]       word;
	int                errs = 0;

	// CRC-32 over the unmixed bytes; every fourth byte the inverted CRC is
	// folded back into the word that just went through it.
	function automatic void stir_pool();
		logic [31:0] crc;
		logic [31:0] m;
		crc = CRC_INIT;
		for (int i = 0; i < POOL_BYTES; i++) begin
			crc = crc ^ {24'd0, pool_img[i]};
			for (int k = 0; k < 8; k++)
				crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
			if (i % 4 == 3) begin
				m = ~crc;
				for (int j = 0; j < 4; j++)
					pool_img[i - 3 + j] = pool_img[i - 3 + j] ^ m[8*j +: 8];
			end
		end
	endfunction

	// Takes one pair; returns 1 and the word when a fill completes.
	function automatic logic absorb_pair(input logic a, input logic b,
			output logic [63:0] w);
		int fill_eff;
		w = '0;
		if (a == b)
			return 1'b0;
		if (fill_len == 0)
			fill_eff = 1;
		else if (fill_len > POOL_BYTES)
			fill_eff = POOL_BYTES;
		else
			fill_eff = fill_len;
		if (byte_pos >= POOL_BYTES)
			byte_pos = 0;
		pool_img[byte_pos][bit_pos] = pool_img[byte_pos][bit_pos] ^ b;
		bit_pos = bit_pos + 3'd1;
		if (bit_pos != 3'd0)
			return 1'b0;
		byte_pos++;
		if (byte_pos < fill_eff)
			return 1'b0;
		stir_pool();
		byte_pos = 0;
		for (int k = 0; k < 8; k++)
			w[8*k +: 8] = pool_img[k];
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOL_BYTES; i++)
				pool_img[i] = POOL_INIT;
			byte_pos = 0;
			bit_pos = '0;
			fill_len = FILL_RESET;
			expected_words.delete();
			word_errors <= errs;
			words_pending <= 0;
		end else begin
			// Outputs are checked first, so a word predicted at this edge
			// can never be matched by a transaction at the same edge.
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					errs++;
					$display("%0t pool_word_checker: unexpected random_word %h, expected none",
						$time, random_word);
				end else begin
					want = expected_words.pop_front();
					if (random_word !== want) begin
						errs++;
						$display("%0t pool_word_checker: random_word expected %h, got %h",
							$time, want, random_word);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				fill_len = fill_bytes;
			if (in_valid && in_ready) begin
				if (absorb_pair(first_raw_bit, second_raw_bit, word))
					expected_words.push_back(word);
			end
			word_errors <= errs;
			words_pending <= expected_words.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// Entropy pool conditioner testbench
// Drives bit pairs and fill lengths into the conditioner, randomizes both
// handshakes and lets the pool word checker judge every output transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import epc_pkg::*;

	localparam int POOL_BYTES = 64;

	// Number of random phases, the phase in which the receiver holds off for
	// a long stretch, and the phase run without any idle cycles.
	localparam int NPH         = 10;
	localparam int HOLD_PHASE  = 1;
	localparam int CALM_PHASE  = 2;
	localparam int HOLD_CYCLES = 600;

	// Cycles allowed for the block to drain its pair queue once no word is
	// expected, and the longer wait at the end that also covers a full mix.
	localparam int DRAIN_CYCLES = 50;
	localparam int TAIL_CYCLES  = 400;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [FILL_W-1:0] fill_bytes = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              first_raw_bit = 1'b0;
	logic              second_raw_bit = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [63:0]       random_word;

	int                word_errors;
	int                words_pending;

	// Phase control shared between the sender and the receiver.
	int                phase_no = -1;
	bit                calm = 1'b0;

	// Fill length and number of kept pairs of each random phase. Most phases
	// use short fills so that words come often. The 64 and 127 phases make
	// one long fill (the second saturates to the pool size), and the drop to
	// 3 that follows lands in the middle of a fill.
	int phase_fill [NPH] = '{8, 1, 2, 0, 64, 127, 3, 1, 5, 2};
	int phase_kept [NPH] = '{110, 110, 110, 100, 60, 500, 110, 110, 100, 100};

	always #5 clk = ~clk;

	entropy_pool_conditioner_top #(
		.POOL_BYTES(POOL_BYTES)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.fill_bytes     (fill_bytes),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.first_raw_bit  (first_raw_bit),
		.second_raw_bit (second_raw_bit),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.random_word    (random_word)
	);

	pool_word_checker #(
		.POOL_BYTES(POOL_BYTES)
	) checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.fill_bytes     (fill_bytes),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.first_raw_bit  (first_raw_bit),
		.second_raw_bit (second_raw_bit),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.random_word    (random_word),
		.word_errors    (word_errors),
		.words_pending  (words_pending)
	);

	// One configuration transaction. It is called just after clk rises and
	// returns once the write has been taken.
	task automatic write_fill(input int v);
		cfg_valid <= 1'b1;
		fill_bytes <= v[FILL_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One pair transaction, preceded by random idle cycles unless the phase
	// is calm. Valid is left high on return; the next call or the caller
	// decides whether it drops, so it is never lowered and raised in one step.
	task automatic send_pair(input logic a, input logic b);
		while (!calm && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		first_raw_bit <= a;
		second_raw_bit <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Random pairs until the given number of whitened bits went in. Three in
	// four pairs carry a bit; the rest are the pairs the corrector drops.
	task automatic run_phase(input int kept_target);
		int kept;
		logic a;
		logic b;
		kept = 0;
		while (kept < kept_target) begin
			if ($urandom_range(99) < 75) begin
				b = 1'($urandom_range(1));
				a = ~b;
				kept++;
			end else begin
				a = 1'($urandom_range(1));
				b = a;
			end
			send_pair(a, b);
		end
		in_valid <= 1'b0;
	endtask

	// The sender pauses until every predicted word has been taken, then
	// gives the pair queue time to empty before the fill length may change.
	task automatic settle();
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Receiver. It stalls about 30 percent of the time, never in the calm
	// phase, and once holds off for a long stretch so that the output
	// register, the back end and then the pair queue all fill up and the
	// block stops taking pairs while the sender keeps offering them.
	initial begin : receiver
		bit held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && phase_no == HOLD_PHASE) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(99) < 30) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A zero fill length acts as one byte. Both dropped
		// pairs go first and must leave no trace; then one byte of all ones
		// and one byte of all zeros each complete a fill and give a word.
		write_fill(0);
		send_pair(1'b0, 1'b0);
		send_pair(1'b1, 1'b1);
		repeat (8) send_pair(1'b0, 1'b1);
		repeat (8) send_pair(1'b1, 1'b0);
		in_valid <= 1'b0;
		settle();

		// Random phases. The fill length changes only while nothing is in
		// flight, but a partly filled pool carries over into the next phase.
		for (int p = 0; p < NPH; p++) begin
			phase_no <= p;
			calm <= (p == CALM_PHASE);
			write_fill(phase_fill[p]);
			run_phase(phase_kept[p]);
			settle();
		end

		// A word that shows up now, after the last expected one, counts as
		// a failure in the checker.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (word_errors == 0 && words_pending == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	// Watchdog for a block that stops answering.
	initial begin : watchdog
		#5_000_000;
		$display("tb: FAIL");
		$finish;
	end

endmodule

// ----- entropy_pool_conditioner_top.f -----
rtl/epc_pkg.sv
rtl/epc_front.sv
rtl/epc_back.sv
rtl/entropy_pool_conditioner_top.sv
sim/pool_word_checker.sv
sim/tb.sv
